// ----- rtl/core/mpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types, character codes and prefix tables for the mounted path
// canonicalizer.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // Most beats one input byte can cause: separator, two held dots, the byte
    // itself, and the closing status beat.
    localparam int MAX_BEATS = 5;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);

    localparam logic [3:0] ENGINE_LEN  = 4'd8;
    localparam logic [3:0] PROJECT_LEN = 4'd9;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_P      = 8'h70;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_NO_MOUNT = 2'd1;
    localparam logic [1:0] VERDICT_BAD_PATH = 2'd2;
    localparam logic [1:0] VERDICT_EMPTY    = 2'd3;

    localparam logic MOUNT_ENGINE  = 1'b0;
    localparam logic MOUNT_PROJECT = 1'b1;

    typedef struct packed {
        logic [3:0] prefix_pos;
        logic       mount_sel;
        logic [1:0] held_dots;
        logic       emitted_segment;
        logic       in_segment;
        logic [1:0] error_code;
    } mpc_state_t;

    typedef struct packed {
        logic [7:0] canon_byte;
        logic       byte_present;
        logic       mount_kind;
        logic [1:0] verdict;
        logic       path_done;
    } mpc_beat_t;

    // Expected prefix byte at a position for the chosen mount.
    function automatic logic [7:0] prefix_char(input logic mount, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (mount == MOUNT_PROJECT) begin
            case (pos)
                4'd0:    ch = "_";
                4'd1:    ch = "p";
                4'd2:    ch = "r";
                4'd3:    ch = "o";
                4'd4:    ch = "j";
                4'd5:    ch = "e";
                4'd6:    ch = "c";
                4'd7:    ch = "t";
                4'd8:    ch = "/";
                default: ch = 8'h00;
            endcase
        end else begin
            case (pos)
                4'd0:    ch = "_";
                4'd1:    ch = "e";
                4'd2:    ch = "n";
                4'd3:    ch = "g";
                4'd4:    ch = "i";
                4'd5:    ch = "n";
                4'd6:    ch = "e";
                4'd7:    ch = "/";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    // Control bytes and the reserved set < > : " | ? *
    function automatic logic is_forbidden(input logic [7:0] c);
        return (c < CH_SPACE) || (c == "<") || (c == ">") || (c == ":") ||
               (c == 8'h22) || (c == "|") || (c == "?") || (c == "*");
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mounted_path_canonicalizer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mounted_path_canonicalizer_core
// Streams a path in byte by byte and streams out its canonical form, closed
// by one status beat per path.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat payload
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | path_byte, end_of_path
//  m_      | out       | canon_byte, byte_present, mount_kind, verdict,
//          |           | path_done
//
//  Rate: one input beat per cycle while each byte yields at most one output
//  beat and the output is not stalled. A byte that flushes held dots or ends
//  a path yields 1 to 5 beats, holding the input until its last beat leaves;
//  the buffer drains one beat per unstalled cycle into the output register.
//  Reset: aresetn, synchronous, active low; clears path state, buffer count
//  and output valid. No clearing pass.
//  Stalls: a stalled output holds its register; input is taken only while
//  the burst buffer is empty or its last entry leaves, so bytes that yield
//  nothing keep flowing and the first one yielding output waits in the buffer.
// ----------------------------------------------------------------------------
module mounted_path_canonicalizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_path_byte,
    input  logic       s_end_of_path,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_canon_byte,
    output logic       m_byte_present,
    output logic       m_mount_kind,
    output logic [1:0] m_verdict,
    output logic       m_path_done
);
    import mpc_pkg::*;

    // path tracking state, updated on each accepted beat
    mpc_state_t       state_reg;
    mpc_state_t       state_next;

    // burst buffer: head at entry 0, shifts down on each pop
    mpc_beat_t        buf_reg [MAX_BEATS];
    mpc_beat_t        burst   [MAX_BEATS];
    logic [CNT_W-1:0] burst_cnt;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;

    // output register
    logic             m_valid_reg;
    logic             m_valid_next;
    mpc_beat_t        m_beat_reg;

    logic             s_fire;
    logic             out_load;
    logic             pop;

    mpc_step u_step (
        .cur_state   (state_reg),
        .path_byte   (s_path_byte),
        .end_of_path (s_end_of_path),
        .next_state  (state_next),
        .burst       (burst),
        .burst_cnt   (burst_cnt)
    );

    // output register free this cycle
    assign out_load = !m_valid_reg || m_ready;
    assign pop      = (rem_reg != '0) && out_load;
    // take a new beat once the buffer is empty or its last entry leaves now
    assign s_ready  = (rem_reg == '0) || (rem_reg == CNT_W'(1) && out_load);
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        if (s_fire) begin
            rem_next = burst_cnt;
        end else if (pop) begin
            rem_next = rem_reg - CNT_W'(1);
        end else begin
            rem_next = rem_reg;
        end
        m_valid_next = out_load ? (rem_reg != '0) : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_beat_reg <= buf_reg[0];
        end
        if (s_fire) begin
            buf_reg <= burst;
        end else if (pop) begin
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_canon_byte   = m_beat_reg.canon_byte;
    assign m_byte_present = m_beat_reg.byte_present;
    assign m_mount_kind   = m_beat_reg.mount_kind;
    assign m_verdict      = m_beat_reg.verdict;
    assign m_path_done    = m_beat_reg.path_done;

    // buffer never holds more than one burst
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= CNT_W'(MAX_BEATS))
        else $error("burst buffer count out of range");

    // a beat is either a byte or the closing status, never both
    a_beat_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_beat_reg.byte_present != m_beat_reg.path_done))
        else $error("output beat is neither byte nor status");

    // byte beats carry no verdict
    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_reg.byte_present) |-> (m_beat_reg.verdict == VERDICT_OK))
        else $error("byte beat carries a verdict");

    // the end of a path returns tracking state to reset
    a_path_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_end_of_path) |=> (state_reg == '0))
        else $error("path state not cleared after end of path");

    // first error wins within a path
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.error_code != VERDICT_OK && !(s_fire && s_end_of_path))
        |=> (state_reg.error_code == $past(state_reg.error_code)))
        else $error("path error code changed before end of path");

endmodule
`default_nettype wire

// ----- rtl/core/mpc_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_step
// Per-byte next state and the burst of output beats one input byte causes.
// ----------------------------------------------------------------------------
module mpc_step (
    input  mpc_pkg::mpc_state_t cur_state,
    input  logic [7:0]          path_byte,
    input  logic                end_of_path,
    output mpc_pkg::mpc_state_t next_state,
    output mpc_pkg::mpc_beat_t  burst [mpc_pkg::MAX_BEATS],
    output logic [mpc_pkg::CNT_W-1:0] burst_cnt
);
    import mpc_pkg::*;

    logic [7:0]       c;
    logic [3:0]       plen;
    logic [3:0]       plen_end;
    logic             mnt;
    logic             pref_emit;
    logic             body_emit;
    logic             open_seg;
    logic             sep;
    logic [1:0]       dots;
    logic [CNT_W-1:0] nbytes;
    logic [1:0]       final_err;
    mpc_state_t       upd;

    always_comb begin
        c         = (path_byte == CH_BSLASH) ? CH_SLASH : path_byte;
        upd       = cur_state;
        plen      = cur_state.mount_sel ? PROJECT_LEN : ENGINE_LEN;
        mnt       = cur_state.mount_sel;
        pref_emit = 1'b0;
        body_emit = 1'b0;
        open_seg  = 1'b0;

        if (cur_state.error_code == VERDICT_OK) begin
            if (cur_state.prefix_pos < plen) begin
                if (cur_state.prefix_pos == 4'd1 && (c == CH_E || c == CH_P)) begin
                    mnt = (c == CH_P);
                end
                upd.mount_sel = mnt;
                if (c == prefix_char(mnt, cur_state.prefix_pos)) begin
                    pref_emit      = 1'b1;
                    upd.prefix_pos = cur_state.prefix_pos + 4'd1;
                end else begin
                    upd.error_code = VERDICT_NO_MOUNT;
                end
            end else if (c == CH_SLASH) begin
                if (cur_state.held_dots == 2'd2 && !cur_state.in_segment) begin
                    upd.error_code = VERDICT_BAD_PATH;
                end
                upd.held_dots  = 2'd0;
                upd.in_segment = 1'b0;
            end else if (is_forbidden(c)) begin
                upd.error_code = VERDICT_BAD_PATH;
            end else if (c == CH_DOT && !cur_state.in_segment) begin
                if (cur_state.held_dots < 2'd2) begin
                    upd.held_dots = cur_state.held_dots + 2'd1;
                end else begin
                    open_seg  = 1'b1;
                    body_emit = 1'b1;
                end
            end else begin
                open_seg  = !cur_state.in_segment;
                body_emit = 1'b1;
            end
        end

        // opening a segment flushes separator and held dots ahead of the byte
        sep  = open_seg & cur_state.emitted_segment;
        dots = open_seg ? cur_state.held_dots : 2'd0;
        if (open_seg) begin
            upd.held_dots       = 2'd0;
            upd.in_segment      = 1'b1;
            upd.emitted_segment = 1'b1;
        end

        if (pref_emit) begin
            nbytes = CNT_W'(1);
        end else if (body_emit) begin
            nbytes = CNT_W'(sep) + CNT_W'(dots) + CNT_W'(1);
        end else begin
            nbytes = '0;
        end

        // closing verdict
        plen_end  = upd.mount_sel ? PROJECT_LEN : ENGINE_LEN;
        final_err = upd.error_code;
        if (upd.error_code == VERDICT_OK) begin
            if (upd.prefix_pos < plen_end) begin
                final_err = VERDICT_NO_MOUNT;
            end else if (upd.held_dots == 2'd2 && !upd.in_segment) begin
                final_err = VERDICT_BAD_PATH;
            end else if (!upd.emitted_segment) begin
                final_err = VERDICT_EMPTY;
            end
        end

        for (int i = 0; i < MAX_BEATS; i++) begin
            burst[i] = '0;
            if (CNT_W'(i) < nbytes) begin
                burst[i].byte_present = 1'b1;
                burst[i].mount_kind   = upd.mount_sel;
                if (CNT_W'(i) < CNT_W'(sep)) begin
                    burst[i].canon_byte = CH_SLASH;
                end else if (CNT_W'(i) < CNT_W'(sep) + CNT_W'(dots)) begin
                    burst[i].canon_byte = CH_DOT;
                end else begin
                    burst[i].canon_byte = c;
                end
            end else if (CNT_W'(i) == nbytes && end_of_path) begin
                burst[i].path_done  = 1'b1;
                burst[i].verdict    = final_err;
                burst[i].mount_kind = (final_err == VERDICT_NO_MOUNT) ? MOUNT_ENGINE
                                                                       : upd.mount_sel;
            end
        end

        burst_cnt  = nbytes + CNT_W'(end_of_path);
        next_state = end_of_path ? '0 : upd;
    end

endmodule
`default_nettype wire
